/* hdl/ibk_pkg.sv */
// ----------------------------------------------------------------------------
// ibk_pkg
// Codes, types and constant tables shared by the iambic mode B keyer.
// ----------------------------------------------------------------------------
package ibk_pkg;

	localparam int DitW      = 16;
	localparam int RatioW    = 6;
	localparam int DahW      = 19;
	localparam int TimeW     = 32;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 16;
	localparam int ScaleW    = 28;
	localparam int Div10Sh   = 25;
	localparam int Div10Mult = 3355444;

	localparam logic [RatioW-1:0] RATIO_MIN   = 6'd28;
	localparam logic [RatioW-1:0] RATIO_MAX   = 6'd45;
	localparam logic [RatioW-1:0] RATIO_RESET = 6'd30;
	localparam logic [DitW-1:0]   DIT_RESET   = 16'd100;
	localparam logic [DahW-1:0]   DAH_RESET   = 19'd300;

	localparam logic [CfgIdxW-1:0] REG_DIT   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_RATIO = 2'd1;

	localparam logic [1:0] OP_PADDLE  = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_BEGIN = 2'd1;
	localparam logic [1:0] EV_END   = 2'd2;

	localparam logic [1:0] EL_DIT  = 2'd0;
	localparam logic [1:0] EL_DAH  = 2'd1;
	localparam logic [1:0] EL_NONE = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_MARK = 3'b010,
		PH_GAP  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [DitW-1:0] dit_len;
		logic [DahW-1:0] dah_len;
	} timing_t;

	// ratio times the reciprocal of ten, scaled by 2^Div10Sh
	function automatic logic [ScaleW-1:0] ratio_scale(input logic [RatioW-1:0] r);
		logic [ScaleW-1:0] s;
		begin
			unique case (r)
				6'd29: s = ScaleW'(29 * Div10Mult);
				6'd30: s = ScaleW'(30 * Div10Mult);
				6'd31: s = ScaleW'(31 * Div10Mult);
				6'd32: s = ScaleW'(32 * Div10Mult);
				6'd33: s = ScaleW'(33 * Div10Mult);
				6'd34: s = ScaleW'(34 * Div10Mult);
				6'd35: s = ScaleW'(35 * Div10Mult);
				6'd36: s = ScaleW'(36 * Div10Mult);
				6'd37: s = ScaleW'(37 * Div10Mult);
				6'd38: s = ScaleW'(38 * Div10Mult);
				6'd39: s = ScaleW'(39 * Div10Mult);
				6'd40: s = ScaleW'(40 * Div10Mult);
				6'd41: s = ScaleW'(41 * Div10Mult);
				6'd42: s = ScaleW'(42 * Div10Mult);
				6'd43: s = ScaleW'(43 * Div10Mult);
				6'd44: s = ScaleW'(44 * Div10Mult);
				6'd45: s = ScaleW'(45 * Div10Mult);
				default: s = ScaleW'(28 * Div10Mult);
			endcase
			return s;
		end
	endfunction

endpackage

/* hdl/ibk_timing.sv */
// ----------------------------------------------------------------------------
// ibk_timing
// Configuration registers and the registered dah length computation.
// ----------------------------------------------------------------------------
module ibk_timing (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ibk_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [ibk_pkg::CfgDataW-1:0]      cfg_data,
	output ibk_pkg::timing_t                  timing
);

	localparam int ProdW = ibk_pkg::DitW + ibk_pkg::ScaleW;

	logic [ibk_pkg::DitW-1:0]   dit_q;
	logic [ibk_pkg::RatioW-1:0] ratio_q;
	logic [ibk_pkg::DahW-1:0]   dah_q;
	logic [ibk_pkg::RatioW-1:0] ratio_in;
	logic [ibk_pkg::RatioW-1:0] ratio_clamped;
	logic [ProdW-1:0]           prod;

	assign ratio_in = cfg_data[ibk_pkg::RatioW-1:0];

	always_comb begin
		priority if (ratio_in < ibk_pkg::RATIO_MIN) begin
			ratio_clamped = ibk_pkg::RATIO_MIN;
		end else if (ratio_in > ibk_pkg::RATIO_MAX) begin
			ratio_clamped = ibk_pkg::RATIO_MAX;
		end else begin
			ratio_clamped = ratio_in;
		end
	end

	// (dit * ratio + 5) / 10 as one multiply by a scaled reciprocal
	assign prod = ProdW'(dit_q) * ProdW'(ibk_pkg::ratio_scale(ratio_q))
		+ ProdW'(5 * ibk_pkg::Div10Mult);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dit_q   <= ibk_pkg::DIT_RESET;
			ratio_q <= ibk_pkg::RATIO_RESET;
			dah_q   <= ibk_pkg::DAH_RESET;
		end else begin
			dah_q <= prod[ibk_pkg::Div10Sh +: ibk_pkg::DahW];
			if (cfg_we && cfg_index == ibk_pkg::REG_DIT) begin
				dit_q <= cfg_data[ibk_pkg::DitW-1:0];
			end
			if (cfg_we && cfg_index == ibk_pkg::REG_RATIO) begin
				ratio_q <= ratio_clamped;
			end
		end
	end

	assign timing.dit_len = dit_q;
	assign timing.dah_len = dah_q;

endmodule

/* hdl/ibk_core.sv */
// ----------------------------------------------------------------------------
// ibk_core
// Input register, keyer state update and result register.
// ----------------------------------------------------------------------------
module ibk_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ibk_pkg::timing_t              timing,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic                          paddle,
	input  logic                          pressed,
	input  logic [ibk_pkg::TimeW-1:0]     now_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    event_res,
	output logic                          element,
	output logic                          keying
);

	// input stage
	logic                          valid_s1;
	logic [1:0]                    op_s1;
	logic                          paddle_s1;
	logic                          pressed_s1;
	logic [ibk_pkg::TimeW-1:0]     now_s1;

	// keyer state
	logic [1:0]                    pd_q;
	logic                          keyed_q;
	logic [1:0]                    cur_q;
	logic [1:0]                    last_q;
	logic [1:0]                    first_q;
	logic                          sq_q;
	ibk_pkg::phase_t               phase_q;
	logic [ibk_pkg::TimeW-1:0]     deadline_q;

	logic [1:0]                    pd_n;
	logic                          keyed_n;
	logic [1:0]                    cur_n;
	logic [1:0]                    last_n;
	logic [1:0]                    first_n;
	logic                          sq_n;
	ibk_pkg::phase_t               phase_n;
	logic [ibk_pkg::TimeW-1:0]     deadline_n;
	logic [1:0]                    ev_n;
	logic                          el_n;

	// result register
	logic                          out_valid_q;
	logic [1:0]                    event_q;
	logic                          element_q;
	logic                          keying_q;

	logic                          advance;
	logic                          accept;

	logic [1:0]                    pick_el;
	logic                          pick_sq;
	logic [1:0]                    pick_first;
	logic [1:0]                    pd_set;
	logic [ibk_pkg::TimeW-1:0]     diff;
	logic                          expired;
	logic [ibk_pkg::TimeW-1:0]     mark_len;

	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// next element choice
	always_comb begin
		pick_el    = ibk_pkg::EL_NONE;
		pick_sq    = sq_q;
		pick_first = first_q;
		priority if (pd_q[0] && pd_q[1]) begin
			pick_sq = 1'b1;
			if (last_q == ibk_pkg::EL_NONE) begin
				pick_first = ibk_pkg::EL_NONE;
				pick_el    = (first_q != ibk_pkg::EL_NONE) ? first_q : ibk_pkg::EL_DIT;
			end else begin
				pick_el = {1'b0, ~last_q[0]};
			end
		end else if (pd_q[0] || pd_q[1]) begin
			pick_sq    = 1'b0;
			pick_first = ibk_pkg::EL_NONE;
			pick_el    = pd_q[0] ? ibk_pkg::EL_DIT : ibk_pkg::EL_DAH;
		end else if (sq_q && last_q != ibk_pkg::EL_NONE) begin
			pick_sq = 1'b0;
			pick_el = {1'b0, ~last_q[0]};
		end else begin
			pick_el = ibk_pkg::EL_NONE;
		end
	end

	assign diff     = now_s1 - deadline_q;
	assign expired  = !diff[ibk_pkg::TimeW-1];
	assign mark_len = (pick_el == ibk_pkg::EL_DAH) ?
		ibk_pkg::TimeW'(timing.dah_len) : ibk_pkg::TimeW'(timing.dit_len);
	assign pd_set   = pressed_s1 ? (pd_q | (2'b01 << paddle_s1))
		: (pd_q & ~(2'b01 << paddle_s1));

	always_comb begin
		pd_n       = pd_q;
		keyed_n    = keyed_q;
		cur_n      = cur_q;
		last_n     = last_q;
		first_n    = first_q;
		sq_n       = sq_q;
		phase_n    = phase_q;
		deadline_n = deadline_q;
		ev_n       = ibk_pkg::EV_NONE;
		el_n       = 1'b0;
		unique case (op_s1)
			ibk_pkg::OP_PADDLE: begin
				if (pressed_s1 && pd_q == 2'b00 && phase_q == ibk_pkg::PH_IDLE) begin
					first_n = {1'b0, paddle_s1};
				end
				pd_n = pd_set;
				if (pd_set == 2'b11) begin
					sq_n = 1'b1;
				end
			end
			ibk_pkg::OP_TICK: begin
				if (phase_q == ibk_pkg::PH_IDLE || (phase_q == ibk_pkg::PH_GAP && expired)) begin
					sq_n    = pick_sq;
					first_n = pick_first;
					if (pick_el != ibk_pkg::EL_NONE) begin
						cur_n      = pick_el;
						last_n     = pick_el;
						first_n    = ibk_pkg::EL_NONE;
						keyed_n    = 1'b1;
						phase_n    = ibk_pkg::PH_MARK;
						deadline_n = now_s1 + mark_len;
						ev_n       = ibk_pkg::EV_BEGIN;
						el_n       = pick_el[0];
					end else if (phase_q == ibk_pkg::PH_GAP) begin
						phase_n = ibk_pkg::PH_IDLE;
						last_n  = ibk_pkg::EL_NONE;
						first_n = ibk_pkg::EL_NONE;
					end
				end else if (phase_q == ibk_pkg::PH_MARK && expired) begin
					ev_n       = ibk_pkg::EV_END;
					el_n       = cur_q[0];
					keyed_n    = 1'b0;
					cur_n      = ibk_pkg::EL_NONE;
					phase_n    = ibk_pkg::PH_GAP;
					deadline_n = now_s1 + ibk_pkg::TimeW'(timing.dit_len);
				end
			end
			ibk_pkg::OP_RELEASE: begin
				if (keyed_q) begin
					ev_n = ibk_pkg::EV_END;
					el_n = cur_q[0];
				end
				pd_n       = 2'b00;
				keyed_n    = 1'b0;
				cur_n      = ibk_pkg::EL_NONE;
				last_n     = ibk_pkg::EL_NONE;
				first_n    = ibk_pkg::EL_NONE;
				sq_n       = 1'b0;
				phase_n    = ibk_pkg::PH_IDLE;
				deadline_n = '0;
			end
			default: begin
				ev_n = ibk_pkg::EV_NONE;
			end
		endcase
	end

	// hold the input item until it advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= operation;
			paddle_s1  <= paddle;
			pressed_s1 <= pressed;
			now_s1     <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pd_q       <= 2'b00;
			keyed_q    <= 1'b0;
			cur_q      <= ibk_pkg::EL_NONE;
			last_q     <= ibk_pkg::EL_NONE;
			first_q    <= ibk_pkg::EL_NONE;
			sq_q       <= 1'b0;
			phase_q    <= ibk_pkg::PH_IDLE;
			deadline_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pd_q       <= pd_n;
				keyed_q    <= keyed_n;
				cur_q      <= cur_n;
				last_q     <= last_n;
				first_q    <= first_n;
				sq_q       <= sq_n;
				phase_q    <= phase_n;
				deadline_q <= deadline_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q   <= ev_n;
			element_q <= el_n;
			keying_q  <= keyed_n;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;
	assign element   = element_q;
	assign keying    = keying_q;

endmodule

/* hdl/iambic_b_keyer.sv */
// ----------------------------------------------------------------------------
// iambic_b_keyer
// Iambic mode B Morse keyer with a configuration write port.
// ----------------------------------------------------------------------------
// Path from input accept to result valid: the input register, then the result
// register. Throughput: one item per cycle while out_stall does not hold the result,
// set by the single state update between the two registers. A configuration write
// loads the dit or ratio register, and the dah length register then reloads from them.
// Reset: asynchronous, clears keyer state and loads the default timing.
module iambic_b_keyer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic                          paddle,
	input  logic                          pressed,
	input  logic [ibk_pkg::TimeW-1:0]     now_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    event_res,
	output logic                          element,
	output logic                          keying,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ibk_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [ibk_pkg::CfgDataW-1:0]  cfg_data
);

	ibk_pkg::timing_t timing;

	assign cfg_ready = 1'b1;

	ibk_timing u_timing (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.timing    (timing)
	);

	ibk_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.timing    (timing),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.paddle    (paddle),
		.pressed   (pressed),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_res (event_res),
		.element   (element),
		.keying    (keying)
	);

endmodule
